/* hw/rtl/dlsx_pkg.sv */
// shared types, constants and helper functions of the dda line scaler
`default_nettype none

package dlsx_pkg;

  localparam int PIX_W           = 48;
  localparam int PIX_BYTES       = 6;
  localparam int POS_W           = 19;
  localparam int LEN_W           = 16;
  localparam int ZOOM_W          = 16;
  localparam int ACC_W           = 18;
  localparam int MODE_W          = 3;
  localparam int NB_W            = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_PIXEL_BYTES = 6;
  localparam int DDA_UNIT        = 1000;
  localparam int ZOOM_FLOOR      = 16;

  // pixel modes
  localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BINARY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GRAY   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RGB    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RGB48  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LINE_BYTES = 2'd2;

  // reset values
  localparam logic [MODE_W-1:0] PIXEL_MODE_RST = MODE_GRAY;
  localparam logic [ZOOM_W-1:0] ZOOM_STEP_RST  = ZOOM_W'(DDA_UNIT);

  // accumulator commands
  localparam logic [1:0] ACC_HOLD     = 2'd0;
  localparam logic [1:0] ACC_LOAD_SUM = 2'd1;
  localparam logic [1:0] ACC_CLEAR    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] pixel_mode;
    logic [ZOOM_W-1:0] zoom_step;
    logic [LEN_W-1:0]  out_line_bytes;
  } cfg_t;

  typedef struct packed {
    logic       sel_unit;  // 1: add minus one unit, 0: add zoom step
    logic [1:0] op;
  } acc_ctl_t;

  typedef struct packed {
    logic acc_neg;
    logic sum_neg;
  } acc_stat_t;

  // bytes per pixel, zero for binary mode and for modes without a dda run
  function automatic logic [NB_W-1:0] mode_bytes(input logic [MODE_W-1:0] mode);
    logic [NB_W-1:0] n;
    unique case (mode)
      MODE_GRAY:  n = 3'd1;
      MODE_RGB:   n = 3'd3;
      MODE_RGB48: n = 3'd6;
      default:    n = 3'd0;
    endcase
    if (int'(n) > MAX_PIXEL_BYTES) n = NB_W'(MAX_PIXEL_BYTES);
    if (int'(n) > PIX_BYTES) n = NB_W'(PIX_BYTES);
    return n;
  endfunction

  // pixel masked to the size the mode uses
  function automatic logic [PIX_W-1:0] pixel_mask(input logic [MODE_W-1:0] mode,
                                                  input logic [PIX_W-1:0]  pix);
    logic [PIX_W-1:0] m;
    logic [NB_W-1:0]  nb;
    m  = '0;
    nb = mode_bytes(mode);
    if (mode == MODE_BINARY) begin
      m[0] = pix[0];
    end else if (nb == '0) begin
      m[7:0] = pix[7:0];
    end else begin
      for (int j = 0; j < PIX_BYTES; j++) begin
        if (j < int'(nb)) m[j*8 +: 8] = pix[j*8 +: 8];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dlsx_cfg_regs.sv */
// configuration registers with the zoom step floor
`default_nettype none

module dlsx_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [dlsx_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [dlsx_pkg::ZOOM_W-1:0]     wr_data,
  output dlsx_pkg::cfg_t                       cfg
);

  dlsx_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        dlsx_pkg::REG_PIXEL_MODE: cfg_nxt.pixel_mode = wr_data[dlsx_pkg::MODE_W-1:0];
        dlsx_pkg::REG_ZOOM_STEP: begin
          if (wr_data < dlsx_pkg::ZOOM_W'(dlsx_pkg::ZOOM_FLOOR)) begin
            cfg_nxt.zoom_step = dlsx_pkg::ZOOM_W'(dlsx_pkg::ZOOM_FLOOR);
          end else begin
            cfg_nxt.zoom_step = wr_data;
          end
        end
        dlsx_pkg::REG_OUT_LINE_BYTES: cfg_nxt.out_line_bytes = wr_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode     <= dlsx_pkg::PIXEL_MODE_RST;
      cfg_r.zoom_step      <= dlsx_pkg::ZOOM_STEP_RST;
      cfg_r.out_line_bytes <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/dlsx_acc_unit.sv */
// dda accumulator with its single shared adder
`default_nettype none

module dlsx_acc_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dlsx_pkg::ZOOM_W-1:0]  zoom_step,
  input  dlsx_pkg::acc_ctl_t                ctl,
  output dlsx_pkg::acc_stat_t               stat
);

  localparam logic [dlsx_pkg::ACC_W-1:0] MINUS_UNIT =
    dlsx_pkg::ACC_W'(-dlsx_pkg::DDA_UNIT);

  logic [dlsx_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [dlsx_pkg::ACC_W-1:0] operand;
  logic [dlsx_pkg::ACC_W-1:0] sum;

  assign operand = ctl.sel_unit ? MINUS_UNIT
                                : {{(dlsx_pkg::ACC_W-dlsx_pkg::ZOOM_W){1'b0}}, zoom_step};
  assign sum     = acc_r + operand;

  always_comb begin
    unique case (ctl.op)
      dlsx_pkg::ACC_LOAD_SUM: acc_nxt = sum;
      dlsx_pkg::ACC_CLEAR:    acc_nxt = '0;
      default:                acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign stat.acc_neg = acc_r[dlsx_pkg::ACC_W-1];
  assign stat.sum_neg = sum[dlsx_pkg::ACC_W-1];

endmodule

`default_nettype wire

/* hw/rtl/dlsx_seq.sv */
// run sequencer, output position and result register
`default_nettype none

module dlsx_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  dlsx_pkg::cfg_t                    cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [dlsx_pkg::PIX_W-1:0]   in_pixel_data,
  input  wire logic                         in_last_of_line,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [dlsx_pkg::PIX_W-1:0]        out_pixel_out,
  output logic [dlsx_pkg::PIX_BYTES-1:0]    out_byte_enable,
  output logic [dlsx_pkg::POS_W-1:0]        out_out_index,
  output logic                              out_last_of_run,
  output dlsx_pkg::acc_ctl_t                acc_ctl,
  input  dlsx_pkg::acc_stat_t               acc_stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUB  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [dlsx_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [dlsx_pkg::PIX_W-1:0]       pix_r, pix_nxt;
  logic                             eol_r, eol_nxt;

  logic                             ov_r, ov_nxt;
  logic [dlsx_pkg::PIX_W-1:0]       opix_r, opix_nxt;
  logic [dlsx_pkg::PIX_BYTES-1:0]   oen_r, oen_nxt;
  logic [dlsx_pkg::POS_W-1:0]       oidx_r, oidx_nxt;
  logic                             olast_r, olast_nxt;

  logic [dlsx_pkg::NB_W-1:0]        nb;
  logic                             is_binary;
  logic                             is_copy;
  logic [dlsx_pkg::POS_W-1:0]       pos_step;
  logic [dlsx_pkg::POS_W-1:0]       pos_adv;
  logic [dlsx_pkg::POS_W-1:0]       line_len;
  logic [dlsx_pkg::PIX_BYTES-1:0]   en;
  logic                             out_free;
  logic                             accept;
  logic                             finish;

  assign nb        = dlsx_pkg::mode_bytes(cfg.pixel_mode);
  assign is_binary = (cfg.pixel_mode == dlsx_pkg::MODE_BINARY);
  assign is_copy   = !is_binary && (nb == '0);
  assign pos_step  = (nb == '0) ? dlsx_pkg::POS_W'(1)
                                : {{(dlsx_pkg::POS_W-dlsx_pkg::NB_W){1'b0}}, nb};
  assign pos_adv   = pos_r + pos_step;
  assign line_len  = {{(dlsx_pkg::POS_W-dlsx_pkg::LEN_W){1'b0}}, cfg.out_line_bytes};
  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  // byte enables of the copy at the current position
  always_comb begin
    en = '0;
    if (is_binary) begin
      en[0] = (pos_r[dlsx_pkg::POS_W-1:3] < cfg.out_line_bytes);
    end else if (is_copy) begin
      en[0] = (pos_r < line_len);
    end else begin
      for (int j = 0; j < dlsx_pkg::PIX_BYTES; j++) begin
        en[j] = (j < int'(nb)) && ((pos_r + dlsx_pkg::POS_W'(j)) < line_len);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    pix_nxt     = pix_r;
    eol_nxt     = eol_r;
    ov_nxt      = ov_r && out_stall;
    opix_nxt    = opix_r;
    oen_nxt     = oen_r;
    oidx_nxt    = oidx_r;
    olast_nxt   = olast_r;
    acc_ctl     = '{sel_unit: 1'b0, op: dlsx_pkg::ACC_HOLD};
    finish      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pix_nxt   = dlsx_pkg::pixel_mask(cfg.pixel_mode, in_pixel_data);
          eol_nxt   = in_last_of_line;
          state_nxt = is_copy ? ST_RUN : ST_SUB;
        end
      end
      ST_SUB: begin
        // take one unit off; a non-negative result means no copy at all
        acc_ctl.sel_unit = 1'b1;
        acc_ctl.op       = dlsx_pkg::ACC_LOAD_SUM;
        if (!acc_stat.sum_neg) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
          if (eol_r) begin
            acc_ctl.op = dlsx_pkg::ACC_CLEAR;
            pos_nxt    = '0;
          end
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          opix_nxt = pix_r;
          oen_nxt  = en;
          oidx_nxt = pos_r;
          pos_nxt  = pos_adv;
          if (is_copy) begin
            olast_nxt = 1'b1;
            finish    = 1'b1;
          end else begin
            acc_ctl.op = dlsx_pkg::ACC_LOAD_SUM;
            olast_nxt  = !acc_stat.sum_neg;
            finish     = !acc_stat.sum_neg;
          end
          if (finish) begin
            state_nxt = ST_IDLE;
            if (eol_r) begin
              acc_ctl.op = dlsx_pkg::ACC_CLEAR;
              pos_nxt    = '0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    eol_r   <= eol_nxt;
    opix_r  <= opix_nxt;
    oen_r   <= oen_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_pixel_out   = opix_r;
  assign out_byte_enable = oen_r;
  assign out_out_index   = oidx_r;
  assign out_last_of_run = olast_r;

`ifndef SYNTH
  // a dda run only continues while the accumulator is negative
  a_run_needs_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !is_copy |-> acc_stat.acc_neg)
    else $error("dda run with non-negative accumulator");

  // every cycle in the run state with a free output loads a result
  a_run_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && out_free |=> ov_r)
    else $error("run step without result");

  // end of line returns the position to zero
  a_eol_pos: assert property (@(posedge clk) disable iff (!rst_n)
    finish && eol_r |=> (pos_r == '0))
    else $error("position not cleared at end of line");

  // an item in a dda mode always starts with the unit subtract
  a_enter_sub: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_copy |=> (state_r == ST_SUB))
    else $error("dda item skipped the subtract step");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dda_line_scaler_x_unit.sv */
// top level of the dda nearest-neighbor horizontal line scaler
`default_nettype none

// Nearest-neighbor horizontal scaler for one scan line. Each input pixel
// takes 1000 off a signed dda accumulator; while the accumulator is negative
// the pixel is emitted once more at the next output position and zoom_step is
// added back, so zoom_step = trunc(1000 / ratio) enlarges (ratio > 1) or
// shrinks (ratio < 1) the line. A pixel that leaves the accumulator
// non-negative gives no result. Modes: 1 binary (bit 0, positions in bits),
// 2 gray (1 byte), 3 rgb (3 bytes), 4 rgb48 (6 bytes); any other mode passes
// the low byte through once. Bytes at or beyond out_line_bytes come out with
// their enable cleared (binary mode tests bit position / 8). last_of_line
// clears accumulator and position after the pixel's copies. zoom_step writes
// below 16 are raised to 16, which caps a run at 63 copies.
// Steps: after the idle state takes an item, a dda mode takes one unit off in
// the subtract state on the shared accumulator adder (copy mode skips this),
// then gives one copy per cycle through that adder while out_stall allows.
// in_stall is high for the whole item. The result register is separate, so
// the next item is taken while the last copy still waits on out_stall.
// Configuration writes are always ready and must be issued while idle.

module dda_line_scaler_x_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write request
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dlsx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dlsx_pkg::ZOOM_W-1:0]       cfg_data,
  // pixel input request
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dlsx_pkg::PIX_W-1:0]        in_pixel_data,
  input  wire logic                              in_last_of_line,
  // scaled pixel result request
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [dlsx_pkg::PIX_W-1:0]             out_pixel_out,
  output logic [dlsx_pkg::PIX_BYTES-1:0]         out_byte_enable,
  output logic [dlsx_pkg::POS_W-1:0]             out_out_index,
  output logic                                   out_last_of_run
);

  dlsx_pkg::cfg_t      cfg;
  dlsx_pkg::acc_ctl_t  acc_ctl;
  dlsx_pkg::acc_stat_t acc_stat;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  dlsx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // shared adder: minus one unit per pixel, plus zoom_step per copy
  dlsx_acc_unit u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .zoom_step (cfg.zoom_step),
    .ctl       (acc_ctl),
    .stat      (acc_stat)
  );

  // sequencer drives the adder, tracks position and holds the result
  dlsx_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_data   (in_pixel_data),
    .in_last_of_line (in_last_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_byte_enable (out_byte_enable),
    .out_out_index   (out_out_index),
    .out_last_of_run (out_last_of_run),
    .acc_ctl         (acc_ctl),
    .acc_stat        (acc_stat)
  );

endmodule

`default_nettype wire

/* verif/dda_line_scaler_x_unit_tb.sv */
// self-checking testbench for the dda horizontal line scaler with random idling and stalls
`timescale 1ns / 100ps

module dda_line_scaler_x_unit_tb;
  import dlsx_pkg::*;

  localparam int CLK_PERIOD     = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 6;        // an item with no copies still passes the subtract state
  localparam int HOLDOFF_CYCLES = 400;      // long receiver stall that backs up the input
  localparam int LIMIT_CYCLES   = 1500000;  // several times the slowest legal run
  localparam int RUN_CAP        = 64;
  localparam int MAX_PRINTS     = 40;
  localparam int RAND_PHASES    = 16;
  localparam int PHASE_ITEMS    = 23;
  localparam int EOL_PCT        = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one pending input request
  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic             eol;
  } pixel_req_t;

  // one scaled pixel as the block should emit it
  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [PIX_BYTES-1:0] en;
    logic [POS_W-1:0]     idx;
    logic                 last;
  } scaled_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ZOOM_W-1:0]    cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel_data = '0;
  logic             in_last_of_line = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic [PIX_BYTES-1:0] out_byte_enable;
  logic [POS_W-1:0]     out_out_index;
  logic                 out_last_of_run;

  // stimulus and scoreboard state
  pixel_req_t pixel_q[$];      // requests not yet offered to the block
  scaled_px_t scaled_q[$];     // scaled pixels still owed by the block
  pixel_req_t next_px;
  int  n_pushed = 0;           // written only by the stimulus process
  int  n_accepted = 0;         // written only by the monitor
  int  n_errors = 0;
  int  cycle_cnt = 0;
  bit  in_took = 1'b0;         // input request accepted at the last rising edge
  bit  hold_sender = 1'b0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  holdoff_ticket = 0;     // bumped by the stimulus to ask for a long hold-off
  int  holdoff_seen = 0;
  int  holdoff_left = 0;

  // predictor copy of registers and dda state
  logic [MODE_W-1:0] mode_r = PIXEL_MODE_RST;
  logic [ZOOM_W-1:0] zoom_r = ZOOM_STEP_RST;
  logic [LEN_W-1:0]  line_len_r = '0;
  int                dda_acc = 0;
  logic [POS_W-1:0]  line_pos = '0;

  dda_line_scaler_x_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_data   (in_pixel_data),
    .in_last_of_line (in_last_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_byte_enable (out_byte_enable),
    .out_out_index   (out_out_index),
    .out_last_of_run (out_last_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // hang guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("** dda_line_scaler_x_unit: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < MAX_PRINTS)
      $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // register write as the block applies it: mode keeps 3 bits, zoom has a floor
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ZOOM_W-1:0] val);
    case (idx)
      REG_PIXEL_MODE:     mode_r = val[MODE_W-1:0];
      REG_ZOOM_STEP:      zoom_r = (val < ZOOM_FLOOR) ? ZOOM_W'(ZOOM_FLOOR) : val;
      REG_OUT_LINE_BYTES: line_len_r = val;
      default: ;          // unused index, ignored
    endcase
  endtask

  // dda step for one accepted pixel, queues every copy it produces
  task automatic scale_pixel(input logic [PIX_W-1:0] data, input logic eol);
    logic [NB_W-1:0]      nb;
    logic [PIX_W-1:0]     p;
    logic [POS_W-1:0]     byte_pos;
    scaled_px_t           r;
    int                   n;
    int                   j;
    n = 0;
    case (mode_r)
      MODE_GRAY:  nb = 3'd1;
      MODE_RGB:   nb = 3'd3;
      MODE_RGB48: nb = 3'd6;
      default:    nb = 3'd0;
    endcase
    if (mode_r == MODE_BINARY || nb != 0) begin
      p = '0;
      if (mode_r == MODE_BINARY) begin
        p[0] = data[0];
      end else begin
        for (j = 0; j < PIX_BYTES; j++)
          if (j < nb) p[j*8 +: 8] = data[j*8 +: 8];
      end
      dda_acc = dda_acc - DDA_UNIT;
      while (dda_acc < 0 && n < RUN_CAP) begin
        r.pix = p;
        r.en  = '0;
        r.idx = line_pos;
        if (mode_r == MODE_BINARY) begin
          // binary positions count bits, the line length counts bytes
          r.en[0] = (line_pos >> 3) < line_len_r;
          line_pos = line_pos + 19'd1;
        end else begin
          for (j = 0; j < PIX_BYTES; j++) begin
            byte_pos = line_pos + POS_W'(j);
            if (j < nb) r.en[j] = byte_pos < line_len_r;
          end
          line_pos = line_pos + POS_W'(nb);
        end
        dda_acc = dda_acc + int'(zoom_r);
        n++;
        r.last = !(dda_acc < 0 && n < RUN_CAP);
        scaled_q.push_back(r);
      end
    end else begin
      // unsupported mode: low byte once, no dda
      r.pix   = '0;
      r.pix[7:0] = data[7:0];
      r.en    = '0;
      r.en[0] = line_pos < line_len_r;
      r.idx   = line_pos;
      r.last  = 1'b1;
      scaled_q.push_back(r);
      line_pos = line_pos + 19'd1;
    end
    if (eol) begin
      dda_acc  = 0;
      line_pos = '0;
    end
  endtask

  task automatic check_result();
    scaled_px_t e;
    if (scaled_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, index", 64'(out_out_index), 64'd0);
    end else begin
      e = scaled_q.pop_front();
      if (out_pixel_out !== e.pix)
        report_mismatch("pixel_out", 64'(out_pixel_out), 64'(e.pix));
      if (out_byte_enable !== e.en)
        report_mismatch("byte_enable", 64'(out_byte_enable), 64'(e.en));
      if (out_out_index !== e.idx)
        report_mismatch("out_index", 64'(out_out_index), 64'(e.idx));
      if (out_last_of_run !== e.last)
        report_mismatch("last_of_run", 64'(out_last_of_run), 64'(e.last));
    end
  endtask

  // monitor: every handshake is sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        scale_pixel(in_pixel_data, in_last_of_line);
        n_accepted++;
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
    in_took = in_valid && !in_stall;
  end

  // pixel driver: holds a request until taken, then idles at random or sends the next
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pixel_q.size() != 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
        next_px = pixel_q.pop_front();
        in_valid        <= 1'b1;
        in_pixel_data   <= next_px.data;
        in_last_of_line <= next_px.eol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stall, or a long hold-off when the stimulus asks
  always @(negedge clk) begin
    if (holdoff_ticket != holdoff_seen) begin
      holdoff_seen = holdoff_ticket;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // all requests taken and all copies seen, then let a copy-less item finish
  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_pushed || scaled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ZOOM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [ZOOM_W-1:0] mode, input logic [ZOOM_W-1:0] zoom,
                           input logic [LEN_W-1:0] len);
    wait_idle();
    write_reg(REG_PIXEL_MODE, mode);
    write_reg(REG_ZOOM_STEP, zoom);
    write_reg(REG_OUT_LINE_BYTES, len);
  endtask

  // control changes land at the rising edge, away from the driver's falling edge
  task automatic begin_batch(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] data, input logic eol);
    pixel_req_t q;
    q.data = data;
    q.eol  = eol;
    pixel_q.push_back(q);
    n_pushed++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    return PIX_W'({$urandom, $urandom});
  endfunction

  initial begin
    logic [ZOOM_W-1:0] mode_w;
    logic [ZOOM_W-1:0] zoom_w;
    logic [LEN_W-1:0]  len_w;
    int                ph;
    int                i;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: gray, unit zoom, empty line so enables stay low
    begin_batch(0, 0);
    push_pixel('0, 1'b0);
    push_pixel('1, 1'b1);

    // longest run: rgb48 at the zoom floor, all bytes inside the line
    configure(MODE_RGB48, 16'd16, 16'hFFFF);
    begin_batch(0, 0);
    push_pixel('1, 1'b0);
    push_pixel(48'h0123_4567_89AB, 1'b1);

    // binary: bit positions cross the 3-byte line end
    configure(MODE_BINARY, 16'd16, 16'd3);
    begin_batch(0, 0);
    push_pixel(48'h0000_0000_0001, 1'b0);
    push_pixel(48'hFFFF_FFFF_FFFE, 1'b1);

    // rgb downscale by 2: every other pixel skipped, partial enable at the line end
    configure(MODE_RGB, 16'd2000, 16'd7);
    begin_batch(0, 0);
    push_pixel(48'hAAAA_AAAA_AAAA, 1'b0);
    push_pixel(48'h5555_5555_5555, 1'b0);
    push_pixel(48'h00FF_00FF_00FF, 1'b0);
    push_pixel(48'hFF00_FF00_FF00, 1'b0);
    push_pixel(48'h8000_0000_0080, 1'b0);
    push_pixel(48'h7FFF_FFFF_FF7F, 1'b1);

    // copy mode: low byte once, third position past the line
    configure(MODE_COPY, 16'd1000, 16'd2);
    begin_batch(0, 0);
    push_pixel(48'hFFFF_FFFF_FFFF, 1'b0);
    push_pixel(48'h1234_5678_9ABC, 1'b0);
    push_pixel(48'h0000_0000_0000, 1'b1);

    // mode write keeps 3 bits (mode 7 passes through), zoom of zero is raised
    configure(16'hFFFF, 16'd0, 16'hFFFF);
    begin_batch(0, 0);
    push_pixel(48'hCAFE_0000_00EE, 1'b1);

    // write to the unused index changes nothing, zoom 15 raised to the floor
    wait_idle();
    write_reg(REG_PIXEL_MODE, 16'(MODE_GRAY));
    write_reg(REG_UNUSED, 16'h0003);
    write_reg(REG_ZOOM_STEP, 16'd15);
    begin_batch(0, 0);
    push_pixel(48'h0000_0000_00A5, 1'b1);

    // largest zoom: one copy, then the accumulator stays high and pixels are dropped
    configure(MODE_GRAY, 16'hFFFF, 16'd100);
    begin_batch(0, 0);
    push_pixel(48'h0000_0000_0042, 1'b0);
    push_pixel(48'h0000_0000_0024, 1'b1);

    // random phases: random registers, idling rotates through no idle, sender,
    // receiver, both
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      mode_w = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1:    mode_w[MODE_W-1:0] = MODE_W'($urandom_range(0, 7));
        2, 3:    mode_w[MODE_W-1:0] = MODE_BINARY;
        4, 5:    mode_w[MODE_W-1:0] = MODE_GRAY;
        6, 7:    mode_w[MODE_W-1:0] = MODE_RGB;
        default: mode_w[MODE_W-1:0] = MODE_RGB48;
      endcase
      case ($urandom_range(0, 7))
        0:       zoom_w = 16'd16;
        1:       zoom_w = 16'($urandom_range(0, 15));
        2:       zoom_w = 16'hFFFF;
        3:       zoom_w = 16'($urandom_range(999, 1001));
        4:       zoom_w = 16'($urandom_range(16, 200));
        5, 6:    zoom_w = 16'($urandom_range(200, 3000));
        default: zoom_w = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       len_w = '0;
        1:       len_w = 16'hFFFF;
        2:       len_w = 16'($urandom_range(1, 200));
        default: len_w = 16'($urandom);
      endcase
      configure(mode_w, zoom_w, len_w);

      case (ph % 4)
        0:       begin_batch(0, 0);
        1:       begin_batch(57, 0);
        2:       begin_batch(0, 57);
        default: begin_batch(25, 25);
      endcase
      // one phase backs up the block behind a long receiver hold-off
      if (ph == 4) begin
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_ticket++;
      end
      for (i = 0; i < PHASE_ITEMS; i++)
        push_pixel(rand_pixel(), $urandom_range(99) < EOL_PCT);

      // another phase pauses the sender mid-stream until the block has drained
      if (ph == 9) begin
        do @(negedge clk); while (n_accepted < n_pushed - PHASE_ITEMS / 2);
        @(posedge clk);
        hold_sender = 1'b1;
        do @(negedge clk); while (in_valid || scaled_q.size() != 0);
        @(posedge clk);
        hold_sender = 1'b0;
      end
    end

    wait_idle();
    if (scaled_q.size() != 0)
      report_mismatch("copies never delivered", 64'd0, 64'(scaled_q.size()));

    if (n_errors == 0) begin
      $display("** dda_line_scaler_x_unit: PASSED **");
    end else begin
      $display("** dda_line_scaler_x_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dlsx_pkg.sv
hw/rtl/dlsx_cfg_regs.sv
hw/rtl/dlsx_acc_unit.sv
hw/rtl/dlsx_seq.sv
hw/rtl/dda_line_scaler_x_unit.sv
verif/dda_line_scaler_x_unit_tb.sv
